// File: design/abp_pkg.sv
// shared types, constants and microcode store for the aligned bump block pool
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

  localparam int MAX_BLOCKS     = 8;
  localparam int IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
  localparam int ALIGN_LOG2_MAX = 16;

  localparam int SIZE_W   = 32;
  localparam int LOG2_W   = 5;
  localparam int OUTIDX_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RST = 32'd65536;
  localparam logic [LOG2_W-1:0] ALIGN_LOG2_RST   = 5'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2   = 2'd1;

  localparam int PC_W = 4;

  // program step addresses
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_MODE   = 4'd1;
  localparam logic [PC_W-1:0] S_ZERO   = 4'd2;
  localparam logic [PC_W-1:0] S_SCAN   = 4'd3;
  localparam logic [PC_W-1:0] S_FIT    = 4'd4;
  localparam logic [PC_W-1:0] S_NEXT   = 4'd5;
  localparam logic [PC_W-1:0] S_FULL   = 4'd6;
  localparam logic [PC_W-1:0] S_CREATE = 4'd7;
  localparam logic [PC_W-1:0] S_COMMIT = 4'd8;
  localparam logic [PC_W-1:0] S_FAIL   = 4'd9;
  localparam logic [PC_W-1:0] S_CLEAR  = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT   = 4'd11;
  localparam logic [PC_W-1:0] S_DONE   = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCAN_START,
    OP_ALIGN,
    OP_NEXT,
    OP_CREATE,
    OP_COMMIT,
    OP_FAIL,
    OP_CLEAR,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_MODE,
    COND_ZERO,
    COND_SCAN_END,
    COND_FIT,
    COND_FULL,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_input;
    logic mode;
    logic zero;
    logic scan_end;
    logic fit;
    logic full;
    logic out_busy;
  } cond_flags_t;

  // jump to target when the condition holds, otherwise fall through
  function automatic ctrl_word_t microcode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: S_IDLE};
    case (pc)
      S_IDLE:   w = '{op: OP_ACCEPT,     cond: COND_NO_INPUT, target: S_IDLE};
      S_MODE:   w = '{op: OP_NONE,       cond: COND_MODE,     target: S_CLEAR};
      S_ZERO:   w = '{op: OP_SCAN_START, cond: COND_ZERO,     target: S_FAIL};
      S_SCAN:   w = '{op: OP_ALIGN,      cond: COND_SCAN_END, target: S_FULL};
      S_FIT:    w = '{op: OP_NONE,       cond: COND_FIT,      target: S_COMMIT};
      S_NEXT:   w = '{op: OP_NEXT,       cond: COND_ALWAYS,   target: S_SCAN};
      S_FULL:   w = '{op: OP_NONE,       cond: COND_FULL,     target: S_FAIL};
      S_CREATE: w = '{op: OP_CREATE,     cond: COND_ALWAYS,   target: S_EMIT};
      S_COMMIT: w = '{op: OP_COMMIT,     cond: COND_ALWAYS,   target: S_EMIT};
      S_FAIL:   w = '{op: OP_FAIL,       cond: COND_ALWAYS,   target: S_EMIT};
      S_CLEAR:  w = '{op: OP_CLEAR,      cond: COND_ALWAYS,   target: S_EMIT};
      S_EMIT:   w = '{op: OP_EMIT,       cond: COND_OUT_BUSY, target: S_EMIT};
      S_DONE:   w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: S_IDLE};
      default:  w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/aligned_bump_block_pool_unit.sv
// top level of the aligned bump block pool: register file, block table and datapath
`timescale 1ns / 1ps
`default_nettype none

// Aligned bump block pool. Keeps up to eight linear blocks, each with a size and a
// fill offset. An allocate word (mode 0) lands in the first block, in creation
// order, whose fill rounded up to 2**alignment_log2 plus the request still fits;
// with minimal set a block qualifies only at exactly the requested size. When no
// block fits a new one is appended (request size if minimal, else the larger of
// default_block_size and the request) and the result reports offset 0 with
// block_created set. A zero size or a full pool answers ok=0 with all other fields
// zero. A mode 1 word clears every fill and answers ok=1. One item is in work at a
// time, run by a small microprogram; each scanned block costs three steps (align,
// fit compare, advance). Input is taken again after the result is loaded, so the
// next word may be computed while the last result still waits on the output side.
// Configuration writes are accepted whenever the block is out of reset; indexes
// beyond the two registers are dropped. alignment_log2 above 16 acts as 16.
module aligned_bump_block_pool_unit (
  input  wire                                    clk,
  input  wire                                    rst,
  // configuration write channel
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [abp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [abp_pkg::SIZE_W-1:0]             cfg_data,
  // request channel
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire                                    mode,
  input  wire  [abp_pkg::SIZE_W-1:0]             request_size,
  input  wire                                    minimal,
  // result channel
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic                                   ok,
  output logic [abp_pkg::OUTIDX_W-1:0]           block_index,
  output logic [abp_pkg::SIZE_W-1:0]             alloc_offset,
  output logic                                   block_created
);
  import abp_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] default_block_size;
  logic [LOG2_W-1:0] alignment_log2;

  // block table
  logic [SIZE_W-1:0] block_sizes [MAX_BLOCKS];
  logic [SIZE_W-1:0] block_fill  [MAX_BLOCKS];
  logic [CNT_W-1:0]  blocks_in_use;

  // latched request word
  logic              req_mode;
  logic [SIZE_W-1:0] req_size;
  logic              req_minimal;

  // scan state
  logic [CNT_W-1:0]  scan_idx;
  logic [SIZE_W:0]   aligned;

  // staged result before the output register
  logic                res_ok;
  logic [OUTIDX_W-1:0] res_idx;
  logic [SIZE_W-1:0]   res_off;
  logic                res_created;

  ctrl_word_t  ctrl;
  cond_flags_t flags;

  abp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // alignment mask, shift saturated at the top alignment
  logic [LOG2_W-1:0] align_sh;
  logic [SIZE_W:0]   align_mask;
  logic [SIZE_W:0]   aligned_calc;

  always_comb begin
    align_sh     = (alignment_log2 > LOG2_W'(ALIGN_LOG2_MAX)) ?
                   LOG2_W'(ALIGN_LOG2_MAX) : alignment_log2;
    align_mask   = ((SIZE_W + 1)'(1) << align_sh) - (SIZE_W + 1)'(1);
    aligned_calc = ({1'b0, block_fill[scan_idx[IDX_W-1:0]]} + align_mask) & ~align_mask;
  end

  // fit test on the block under scan
  logic [SIZE_W+1:0] fit_end;
  logic              size_match;
  logic              out_busy;
  logic [SIZE_W-1:0] new_size;
  logic [31:0]       scan_idx_wide;
  logic [31:0]       use_idx_wide;

  always_comb begin
    fit_end    = {1'b0, aligned} + {2'b00, req_size};
    size_match = !req_minimal || (block_sizes[scan_idx[IDX_W-1:0]] == req_size);
    out_busy   = out_valid && !out_ready;
    new_size   = req_minimal ? req_size :
                 ((default_block_size > req_size) ? default_block_size : req_size);
    scan_idx_wide = 32'(scan_idx);
    use_idx_wide  = 32'(blocks_in_use);

    flags.no_input = !in_valid;
    flags.mode     = req_mode;
    flags.zero     = (req_size == '0);
    flags.scan_end = (scan_idx == blocks_in_use);
    flags.fit      = size_match &&
                     (fit_end <= {2'b00, block_sizes[scan_idx[IDX_W-1:0]]});
    flags.full     = (blocks_in_use == CNT_W'(MAX_BLOCKS));
    flags.out_busy = out_busy;
  end

  // nothing is taken while reset is held
  assign in_ready  = (ctrl.op == OP_ACCEPT) && !rst;
  assign cfg_ready = !rst;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      default_block_size <= DEFAULT_SIZE_RST;
      alignment_log2     <= ALIGN_LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DEFAULT_SIZE) begin
        default_block_size <= cfg_data;
      end
      if (cfg_index == REG_ALIGN_LOG2) begin
        alignment_log2 <= cfg_data[LOG2_W-1:0];
      end
    end
  end

  // control state: fills, block count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        block_fill[i] <= '0;
      end
      blocks_in_use <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_CREATE: begin
          block_fill[blocks_in_use[IDX_W-1:0]] <= req_size;
          blocks_in_use <= blocks_in_use + 1'b1;
        end
        OP_COMMIT: begin
          // fit_end never exceeds the block size, so it fits in the fill word
          block_fill[scan_idx[IDX_W-1:0]] <= fit_end[SIZE_W-1:0];
        end
        OP_CLEAR: begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            block_fill[i] <= '0;
          end
        end
        OP_NONE, OP_ACCEPT, OP_SCAN_START, OP_ALIGN, OP_NEXT, OP_FAIL, OP_EMIT: begin
        end
      endcase
      // a new result loads once the register is free, else a taken one leaves
      if (ctrl.op == OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          req_mode    <= mode;
          req_size    <= request_size;
          req_minimal <= minimal;
        end
      end
      OP_SCAN_START: scan_idx <= '0;
      OP_ALIGN:      aligned  <= aligned_calc;
      OP_NEXT:       scan_idx <= scan_idx + 1'b1;
      OP_CREATE: begin
        block_sizes[blocks_in_use[IDX_W-1:0]] <= new_size;
        res_ok      <= 1'b1;
        res_idx     <= use_idx_wide[OUTIDX_W-1:0];
        res_off     <= '0;
        res_created <= 1'b1;
      end
      OP_COMMIT: begin
        res_ok      <= 1'b1;
        res_idx     <= scan_idx_wide[OUTIDX_W-1:0];
        res_off     <= aligned[SIZE_W-1:0];
        res_created <= 1'b0;
      end
      OP_FAIL: begin
        res_ok      <= 1'b0;
        res_idx     <= '0;
        res_off     <= '0;
        res_created <= 1'b0;
      end
      OP_CLEAR: begin
        res_ok      <= 1'b1;
        res_idx     <= '0;
        res_off     <= '0;
        res_created <= 1'b0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          ok            <= res_ok;
          block_index   <= res_idx;
          alloc_offset  <= res_off;
          block_created <= res_created;
        end
      end
      OP_NONE: begin
      end
    endcase
  end

  // checks
  logic fill_any;
  always_comb begin
    fill_any = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      fill_any = fill_any | (|block_fill[i]);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    blocks_in_use <= CNT_W'(MAX_BLOCKS))
    else $error("block count above pool size");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (block_index == '0) && (alloc_offset == '0) && !block_created)
    else $error("failed result carries nonzero fields");

  a_created_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_created |-> ok && (alloc_offset == '0))
    else $error("new block result not at offset zero");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_CLEAR |=> !fill_any)
    else $error("fill reset left a nonzero fill");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a word is in work");

endmodule

`default_nettype wire

// File: design/abp_seq.sv
// microprogram sequencer: step counter, control store lookup and jump logic
`timescale 1ns / 1ps
`default_nettype none

module abp_seq (
  input  wire                 clk,
  input  wire                 rst,
  input  abp_pkg::cond_flags_t flags,
  output abp_pkg::ctrl_word_t  ctrl
);
  import abp_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctrl = microcode(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = flags.no_input;
      COND_MODE:     take = flags.mode;
      COND_ZERO:     take = flags.zero;
      COND_SCAN_END: take = flags.scan_end;
      COND_FIT:      take = flags.fit;
      COND_FULL:     take = flags.full;
      COND_OUT_BUSY: take = flags.out_busy;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the aligned bump block pool unit
`timescale 1ns / 1ps

module tb_top;
  import abp_pkg::*;

  // word codes on the request channel
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // a register index the block has no register for, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd2;

  // drain time covers the longest word, a scan over every block, plus the output register
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASE_WORDS  = 120;

  // one result word as the block reports it
  typedef struct packed {
    logic                ok;
    logic [OUTIDX_W-1:0] idx;
    logic [SIZE_W-1:0]   offset;
    logic                created;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              mode         = 1'b0;
  logic [SIZE_W-1:0] request_size = '0;
  logic              minimal      = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                ok;
  logic [OUTIDX_W-1:0] block_index;
  logic [SIZE_W-1:0]   alloc_offset;
  logic                block_created;

  // predictor copy of the pool: sizes, fills, count and the two registers
  logic [SIZE_W-1:0]   blk_size [MAX_BLOCKS];
  logic [SIZE_W:0]     blk_fill [MAX_BLOCKS];
  int                  blk_count;
  logic [SIZE_W-1:0]   pool_default;
  logic [LOG2_W-1:0]   pool_align;

  grant_t      grant_queue[$];
  grant_t      grant_head;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned n_words, n_clears, n_rejected, n_created;
  bit          idle_on;
  int unsigned hold_cycles;

  aligned_bump_block_pool_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .request_size  (request_size),
    .minimal       (minimal),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .block_index   (block_index),
    .alloc_offset  (alloc_offset),
    .block_created (block_created)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit, counted in cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // idle cycles before a word, both sides draw from the same spread
  function automatic int unsigned idle_gap();
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  // first-fit placement of one word; updates the pool copy and returns the grant
  function automatic grant_t predict_grant(input logic word_mode, input logic [SIZE_W-1:0] sz,
                                           input logic exact);
    grant_t      g;
    logic [63:0] mask;
    logic [63:0] start;
    int          k;
    bit          found;
    g     = '0;
    found = 1'b0;
    // alignment saturates at 64 KiB
    mask  = (64'd1 << ((pool_align > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : pool_align)) - 64'd1;
    n_words++;
    if (word_mode == MODE_CLEAR) begin
      // fill clear keeps the blocks, only offsets go back to zero
      for (k = 0; k < MAX_BLOCKS; k++) blk_fill[k] = '0;
      g.ok = 1'b1;
      n_clears++;
    end else if (sz != '0) begin
      for (k = 0; k < blk_count && !found; k++) begin
        start = (64'(blk_fill[k]) + mask) & ~mask;
        if ((!exact || blk_size[k] == sz) && start + 64'(sz) <= 64'(blk_size[k])) begin
          blk_fill[k] = 33'(start + 64'(sz));
          g.ok        = 1'b1;
          g.idx       = OUTIDX_W'(k);
          g.offset    = start[SIZE_W-1:0];
          found       = 1'b1;
        end
      end
      // nothing fits: append a block unless the pool is full
      if (!found && blk_count < MAX_BLOCKS) begin
        blk_size[blk_count] = (exact || sz >= pool_default) ? sz : pool_default;
        blk_fill[blk_count] = {1'b0, sz};
        g.ok      = 1'b1;
        g.idx     = OUTIDX_W'(blk_count);
        g.created = 1'b1;
        blk_count++;
        n_created++;
      end
    end
    if (!g.ok) n_rejected++;
    return g;
  endfunction

  // offer one request word, then record the expected grant once it is taken
  task automatic send_word(input logic word_mode, input logic [SIZE_W-1:0] sz,
                           input logic exact);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= word_mode;
    request_size <= sz;
    minimal      <= exact;
    do @(posedge clk); while (!in_ready);
    grant_queue.push_back(predict_grant(word_mode, sz, exact));
  endtask

  // register write; the last write of a group drops valid again
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      REG_DEFAULT_SIZE: pool_default = data;
      REG_ALIGN_LOG2:   pool_align   = data[LOG2_W-1:0];
      default: ;
    endcase
  endtask

  // stop offering, wait for every grant and let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // zero-size requests on an empty pool and fill clears, one with junk in the other fields
  task automatic test_special_words();
    send_word(MODE_ALLOC, '0, 1'b0);
    send_word(MODE_ALLOC, '0, 1'b1);
    send_word(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_CLEAR, '0, 1'b0);
  endtask

  // exact-size blocks: a second request of the same size cannot share the first block
  task automatic test_exact_blocks();
    send_word(MODE_ALLOC, 32'd100, 1'b1);
    send_word(MODE_ALLOC, 32'd100, 1'b1);
    send_word(MODE_ALLOC, 32'd64, 1'b1);
  endtask

  // default-sized blocks, aligned placement and the largest request
  task automatic test_default_blocks();
    send_word(MODE_ALLOC, 32'd1, 1'b0);
    send_word(MODE_ALLOC, 32'd1, 1'b0);
    send_word(MODE_ALLOC, 32'hFFFF_FFFF, 1'b0);
    send_word(MODE_ALLOC, 32'h8000_0000, 1'b0);
  endtask

  // zero default sizes a new block to the request, then the largest default
  task automatic test_default_extremes();
    settle();
    write_reg(REG_DEFAULT_SIZE, '0, 1'b1);
    send_word(MODE_ALLOC, 32'h0001_0000, 1'b0);
    settle();
    write_reg(REG_DEFAULT_SIZE, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_ALLOC, 32'h0002_0000, 1'b0);
  endtask

  // full pool rejects, alignment from 1 byte up past the saturation point
  task automatic test_full_pool_and_alignment();
    send_word(MODE_ALLOC, 32'd7, 1'b1);
    send_word(MODE_ALLOC, 32'hFFFF_FFFF, 1'b0);
    settle();
    write_reg(REG_ALIGN_LOG2, '0, 1'b1);
    send_word(MODE_ALLOC, 32'd1, 1'b0);
    settle();
    write_reg(REG_ALIGN_LOG2, 32'd16, 1'b1);
    send_word(MODE_ALLOC, 32'd1, 1'b0);
    settle();
    // upper data bits are not part of the register, 31 acts as 16
    write_reg(REG_ALIGN_LOG2, {27'h7FF_FFFF, 5'd31}, 1'b0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_ALLOC, 32'd1, 1'b0);
    send_word(MODE_CLEAR, 32'h5A5A_5A5A, 1'b0);
    send_word(MODE_ALLOC, 32'd100, 1'b1);
    send_word(MODE_ALLOC, 32'd100, 1'b1);
    send_word(MODE_ALLOC, 32'd64, 1'b1);
  endtask

  // long output hold while the sender keeps offering, so the input side stalls
  task automatic test_output_backpressure();
    settle();
    idle_on     = 1'b0;
    hold_cycles = 80;
    repeat (10) send_word(MODE_ALLOC, $urandom_range(1, 64), 1'b0);
    settle();
    idle_on = 1'b1;
  endtask

  // mostly allocations that can land, with clears, zero sizes and odd sizes mixed in
  task automatic send_random_word();
    int unsigned pick;
    logic [SIZE_W-1:0] sz;
    logic exact;
    pick  = $urandom_range(0, 99);
    exact = ($urandom_range(0, 2) == 0);
    if (pick < 8) begin
      send_word(MODE_CLEAR, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 12) begin
      send_word(MODE_ALLOC, '0, exact);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: sz = $urandom_range(1, 300);
        4:          sz = $urandom_range(1, 32'h0002_0000);
        5:          sz = $urandom;
        // sizes of existing blocks, so exact requests find a match
        default:    sz = (blk_count > 0) ? blk_size[$urandom_range(0, blk_count - 1)] : 32'd1;
      endcase
      send_word(MODE_ALLOC, sz, exact);
    end
  endtask

  // random traffic in phases, register settings changed while idle
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      settle();
      idle_on = (phase != 2);
      case (phase)
        0: begin
          write_reg(REG_DEFAULT_SIZE, 32'd1, 1'b0);
          write_reg(REG_ALIGN_LOG2, '0, 1'b1);
        end
        1: begin
          write_reg(REG_DEFAULT_SIZE, 32'hFFFF_FFFF, 1'b0);
          write_reg(REG_ALIGN_LOG2, 32'd16, 1'b1);
        end
        2: begin
          write_reg(REG_DEFAULT_SIZE, $urandom, 1'b0);
          write_reg(REG_ALIGN_LOG2, {27'($urandom), 5'd31}, 1'b1);
        end
        3: begin
          write_reg(REG_DEFAULT_SIZE, '0, 1'b0);
          write_reg(REG_ALIGN_LOG2, 32'd4, 1'b1);
        end
        4: begin
          write_reg(REG_DEFAULT_SIZE, 32'd65536, 1'b0);
          write_reg(REG_ALIGN_LOG2, $urandom_range(0, 31), 1'b1);
        end
        default: begin
          write_reg(REG_DEFAULT_SIZE, $urandom, 1'b0);
          write_reg(REG_ALIGN_LOG2, $urandom_range(1, 3), 1'b1);
        end
      endcase
      repeat (PHASE_WORDS) send_random_word();
    end
  endtask

  // result side: random stalls, plus the long hold when one is asked for
  initial begin : result_sink
    int unsigned stall_n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall_n = idle_gap();
      if (stall_n != 0) begin
        out_ready <= 1'b0;
        repeat (stall_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input logic [SIZE_W-1:0] want,
                                      input logic [SIZE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // every accepted result word against the oldest expected grant
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        $error("result word with no request pending");
        mismatch_count++;
      end else begin
        grant_head = grant_queue.pop_front();
        check_field("ok", 32'(grant_head.ok), 32'(ok));
        check_field("block_index", 32'(grant_head.idx), 32'(block_index));
        check_field("alloc_offset", grant_head.offset, alloc_offset);
        check_field("block_created", 32'(grant_head.created), 32'(block_created));
      end
    end
  end

  initial begin
    // pool copy starts empty with the register reset values
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_size[k] = '0;
      blk_fill[k] = '0;
    end
    blk_count    = 0;
    pool_default = DEFAULT_SIZE_RST;
    pool_align   = ALIGN_LOG2_RST;
    idle_on      = 1'b1;
    hold_cycles  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_special_words();
    test_exact_blocks();
    test_default_blocks();
    test_default_extremes();
    test_full_pool_and_alignment();
    test_output_backpressure();
    test_random_traffic();
    settle();

    $display("covered %0d request words: %0d fill clears, %0d rejected, %0d blocks appended",
             n_words, n_clears, n_rejected, n_created);
    $display("alignments from 1 byte to saturation, default sizes from zero to the maximum");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/abp_pkg.sv
design/abp_seq.sv
design/aligned_bump_block_pool_unit.sv
sim/tb_top.sv
